// ===== sv/cardinal_spline_point_evaluator_top_defines.svh =====
// Assertion macros for the cardinal spline evaluator checker.
// Both sample on clock; the first is also disabled while reset is high.
`ifndef CARDINAL_SPLINE_POINT_EVALUATOR_TOP_DEFINES_SVH
`define CARDINAL_SPLINE_POINT_EVALUATOR_TOP_DEFINES_SVH

`define CSEP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define CSEP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/csep_pkg.sv =====
package csep_pkg;

   localparam int PT_W       = 32;
   localparam int U_W        = 17;
   localparam int FRAC_IN    = 16;
   localparam int TEN_W      = 16;
   localparam int PCNT_W     = 7;
   localparam int S_W        = 17;
   localparam int S_FRAC     = 15;
   localparam int DIFF_W     = 35;
   localparam int PROD_W     = 52;
   localparam int FULL_W     = 54;
   localparam int ACC_W      = 42;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TENSION     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd1;

   localparam logic [U_W-1:0]      ONE_U      = 17'd65536;
   localparam logic [PCNT_W-1:0]   PCNT_MIN   = 7'd4;
   localparam logic [PCNT_W-1:0]   PCNT_RESET = 7'd4;
   localparam logic signed [S_W-1:0] S_ONE    = 17'sd16384;

   typedef struct packed {
      logic                   operation;
      logic [5:0]             point_index;
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
      logic [U_W-1:0]         param_u;
   } req_type;

   typedef struct packed {
      logic signed [PT_W-1:0] curve_x;
      logic signed [PT_W-1:0] curve_y;
   } rsp_type;

endpackage

// ===== sv/csep_ram.sv =====
module csep_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cardinal_spline_point_evaluator_top.sv =====
// Cardinal spline point evaluator. A load transaction writes one control point into the
// table at the accepting edge and gives no result; an evaluate transaction gives one
// point, shown for one cycle with rsp_valid. One transaction is
// taken every clock: busy is high only during reset, and the receiver cannot stall, so
// results leave as they are produced. The table is kept in four copies so that the four
// points of a segment are read at once; latency is set by the coefficient stages and
// the three Horner multiply and round steps. A load is seen by an evaluate that follows
// it in the very next cycle. Configuration writes are always accepted.
module cardinal_spline_point_evaluator_top
   import csep_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int IDX_W  = (AW > 8) ? AW : 8;
   localparam int T_W    = FRAC_BITS + 1;
   localparam int MUL_W  = ACC_W + T_W + 1;
   localparam int UN_W   = U_W + PCNT_W;
   localparam int SEG_W  = UN_W - FRAC_IN;
   localparam int STAGES = 10;
   localparam int MAX_PC = (MAX_POINTS > 127) ? 127 : MAX_POINTS;

   localparam logic [PCNT_W-1:0]       PC_HI  = PCNT_W'(MAX_PC);
   localparam logic signed [FULL_W-1:0] HALF_C = FULL_W'(1) << (S_FRAC - 1);
   localparam logic signed [MUL_W-1:0]  HALF_M = MUL_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(32'h7fff_ffff);
   localparam logic signed [ACC_W-1:0]  SAT_LO = ~SAT_HI;

   function automatic logic signed [MUL_W-1:0] mul_t(input logic signed [ACC_W-1:0] v,
                                                     input logic [T_W-1:0] t);
      return MUL_W'(v) * MUL_W'($signed({1'b0, t}));
   endfunction

   function automatic logic signed [ACC_W-1:0] round_t(input logic signed [MUL_W-1:0] m);
      logic signed [MUL_W-1:0] r;
      r = (m + HALF_M) >>> FRAC_BITS;
      return ACC_W'(r);
   endfunction

   // configuration
   logic signed [TEN_W-1:0] tension_ff;
   logic [PCNT_W-1:0]       point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff     <= '0;
         point_count_ff <= PCNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TENSION: begin
               tension_ff <= csr_data[TEN_W-1:0];
            end
            CSR_POINT_COUNT: begin
               point_count_ff <= csr_data[PCNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   logic signed [S_W-1:0] s15;
   logic [PCNT_W-1:0]     pc_eff;
   logic [PCNT_W-1:0]     n_cur;
   logic [U_W-1:0]        u_clamp;

   assign s15 = S_ONE - S_W'(tension_ff);

   always_comb begin
      if (point_count_ff < PCNT_MIN) begin
         pc_eff = PCNT_MIN;
      end else if (point_count_ff > PC_HI) begin
         pc_eff = PC_HI;
      end else begin
         pc_eff = point_count_ff;
      end
   end

   assign n_cur   = pc_eff - PCNT_W'(3);
   assign u_clamp = (req_item.param_u > ONE_U) ? ONE_U : req_item.param_u;

   // accept
   logic             take;
   logic             eval_accept;
   logic             load_accept;
   logic [IDX_W-1:0] wr_addr_wide;

   assign take         = start && !busy;
   assign eval_accept  = take && (req_item.operation == OP_EVAL);
   assign load_accept  = take && (req_item.operation == OP_LOAD)
                         && (32'(req_item.point_index) < MAX_POINTS);
   assign wr_addr_wide = IDX_W'(req_item.point_index);

   logic [STAGES-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STAGES-2:0], eval_accept};
      end
   end

   // stage 1: segment and ratio
   logic [U_W-1:0]    u1_ff;
   logic [PCNT_W-1:0] n1_ff;

   always_ff @(posedge clock) begin
      u1_ff <= u_clamp;
      n1_ff <= n_cur;
   end

   logic [UN_W-1:0]   un;
   logic [SEG_W-1:0]  seg_raw;
   logic [PCNT_W-1:0] n_m1;
   logic [PCNT_W-1:0] seg;
   logic [UN_W-1:0]   rem_wide;
   logic [U_W-1:0]    rem;
   logic [T_W-1:0]    t_in;

   assign un       = UN_W'(u1_ff) * UN_W'(n1_ff);
   assign seg_raw  = un[UN_W-1:FRAC_IN];
   assign n_m1     = n1_ff - PCNT_W'(1);
   assign seg      = (seg_raw > SEG_W'(n_m1)) ? n_m1 : seg_raw[PCNT_W-1:0];
   assign rem_wide = un - (UN_W'(seg) << FRAC_IN);
   assign rem      = rem_wide[U_W-1:0];

   generate
      if (FRAC_BITS >= FRAC_IN) begin : g_t_up
         assign t_in = T_W'(rem) << (FRAC_BITS - FRAC_IN);
      end else begin : g_t_dn
         assign t_in = T_W'(rem >> (FRAC_IN - FRAC_BITS));
      end
   endgenerate

   logic [T_W-1:0] t_ff [7];

   always_ff @(posedge clock) begin
      t_ff[0] <= t_in;
      for (int k = 1; k < 7; k++) begin
         t_ff[k] <= t_ff[k-1];
      end
   end

   // point table, one copy per tap
   logic [2*PT_W-1:0] rd_data [4];

   generate
      for (genvar i = 0; i < 4; i++) begin : g_tap
         logic [IDX_W-1:0] rd_addr_wide;

         assign rd_addr_wide = IDX_W'(seg) + IDX_W'(i);

         csep_ram #(
            .WIDTH (2 * PT_W),
            .DEPTH (MAX_POINTS)
         ) u_ram (
            .clock   (clock),
            .wr_en   (load_accept),
            .wr_addr (wr_addr_wide[AW-1:0]),
            .wr_data ({req_item.point_y, req_item.point_x}),
            .rd_addr (rd_addr_wide[AW-1:0]),
            .rd_data (rd_data[i])
         );
      end
   endgenerate

   // per-coordinate datapath
   logic signed [PT_W-1:0] lane_res [2];

   generate
      for (genvar c = 0; c < 2; c++) begin : g_lane
         logic signed [PT_W-1:0]   p0, p1, p2, p3;
         logic signed [DIFF_W-1:0] d_a, d_b, d_c, lin;

         assign p0 = rd_data[0][c*PT_W +: PT_W];
         assign p1 = rd_data[1][c*PT_W +: PT_W];
         assign p2 = rd_data[2][c*PT_W +: PT_W];
         assign p3 = rd_data[3][c*PT_W +: PT_W];

         assign d_a = DIFF_W'(p3) - DIFF_W'(p0) - DIFF_W'(p1) + DIFF_W'(p2);
         assign d_b = (DIFF_W'(p0) <<< 1) + DIFF_W'(p1) - (DIFF_W'(p2) <<< 1) - DIFF_W'(p3);
         assign d_c = DIFF_W'(p2) - DIFF_W'(p0);
         assign lin = DIFF_W'(p1) - DIFF_W'(p2);

         // stage 3: tension products
         logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff;
         logic signed [DIFF_W-1:0] lin_ff;
         logic signed [PT_W-1:0]   p1_3_ff;

         always_ff @(posedge clock) begin
            prod_a_ff <= PROD_W'(s15) * PROD_W'(d_a);
            prod_b_ff <= PROD_W'(s15) * PROD_W'(d_b);
            prod_c_ff <= PROD_W'(s15) * PROD_W'(d_c);
            lin_ff    <= lin;
            p1_3_ff   <= p1;
         end

         logic signed [FULL_W-1:0] full_a, full_b, full_c;
         logic signed [FULL_W-1:0] rs_a, rs_b, rs_c;

         assign full_a = FULL_W'(prod_a_ff) + (FULL_W'(lin_ff) <<< 16);
         assign full_b = FULL_W'(prod_b_ff) - (FULL_W'(lin_ff) <<< 16)
                         - (FULL_W'(lin_ff) <<< 15);
         assign full_c = FULL_W'(prod_c_ff);
         assign rs_a   = (full_a + HALF_C) >>> S_FRAC;
         assign rs_b   = (full_b + HALF_C) >>> S_FRAC;
         assign rs_c   = (full_c + HALF_C) >>> S_FRAC;

         // stage 4: coefficients
         logic signed [ACC_W-1:0] a4_ff, b4_ff, c4_ff;
         logic signed [PT_W-1:0]  p1_4_ff;

         always_ff @(posedge clock) begin
            a4_ff   <= ACC_W'(rs_a);
            b4_ff   <= ACC_W'(rs_b);
            c4_ff   <= ACC_W'(rs_c);
            p1_4_ff <= p1_3_ff;
         end

         // stages 5..10: Horner steps
         logic signed [MUL_W-1:0] m5_ff, m7_ff, m9_ff;
         logic signed [ACC_W-1:0] b5_ff, c5_ff, c6_ff, acc6_ff, acc8_ff;
         logic signed [PT_W-1:0]  p1_5_ff, p1_6_ff, p1_7_ff, p1_8_ff, p1_9_ff;
         logic signed [ACC_W-1:0] c7_ff;
         logic signed [ACC_W-1:0] sum10;
         logic signed [PT_W-1:0]  res_ff;

         assign sum10 = round_t(m9_ff) + ACC_W'(p1_9_ff);

         always_ff @(posedge clock) begin
            m5_ff   <= mul_t(a4_ff, t_ff[2]);
            b5_ff   <= b4_ff;
            c5_ff   <= c4_ff;
            p1_5_ff <= p1_4_ff;

            acc6_ff <= round_t(m5_ff) + b5_ff;
            c6_ff   <= c5_ff;
            p1_6_ff <= p1_5_ff;

            m7_ff   <= mul_t(acc6_ff, t_ff[4]);
            c7_ff   <= c6_ff;
            p1_7_ff <= p1_6_ff;

            acc8_ff <= round_t(m7_ff) + c7_ff;
            p1_8_ff <= p1_7_ff;

            m9_ff   <= mul_t(acc8_ff, t_ff[6]);
            p1_9_ff <= p1_8_ff;

            if (sum10 > SAT_HI) begin
               res_ff <= SAT_HI[PT_W-1:0];
            end else if (sum10 < SAT_LO) begin
               res_ff <= SAT_LO[PT_W-1:0];
            end else begin
               res_ff <= sum10[PT_W-1:0];
            end
         end

         assign lane_res[c] = res_ff;
      end
   endgenerate

   assign rsp_valid = v_ff[STAGES-1];
   assign rsp_item  = '{curve_x: lane_res[0], curve_y: lane_res[1]};

endmodule

// ===== sv/csep_checker.sv =====
`include "cardinal_spline_point_evaluator_top_defines.svh"

module csep_checker
   import csep_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid
);

   localparam int LATENCY = 10;

   logic eval_take;
   logic load_take;

   assign eval_take = start && !busy && (req_item.operation == OP_EVAL);
   assign load_take = start && !busy && (req_item.operation == OP_LOAD);

   `CSEP_ASSERT(a_eval_gives_result, eval_take |-> ##LATENCY rsp_valid, "evaluate lost")
   `CSEP_ASSERT(a_load_no_result, load_take |-> ##LATENCY !rsp_valid, "load gave a result")
   `CSEP_ASSERT(a_result_has_source, rsp_valid |-> $past(eval_take, LATENCY), "result invented")
   `CSEP_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result after reset")

endmodule

bind cardinal_spline_point_evaluator_top csep_checker u_csep_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid)
);
